FILE: sv/pom_pkg.sv
package pom_pkg;

  // Fixed field widths
  localparam int RAW_W      = 24;
  localparam int OUT_W      = 24;
  localparam int WIN_REG_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int STATUS_W   = 2;

  // Window length after reset
  localparam logic [WIN_REG_W-1:0] WINDOW_RESET = 7'd16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEG_TOL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BELOW_TOL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_WIN_ZERO  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_UPDATE,
    ST_DIV,
    ST_FINISH
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;   // capture the input transfer
    logic check;     // latch the result status, issue the ring read
    logic clr;       // empty the store
    logic update;    // write the ring, update the sum, start the divide
    logic out_load;  // move the result into the output register
  } pom_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic func;      // captured item is a clear command
    logic reject;    // captured sample fails (window zero or below tolerance)
    logic div_busy;
    logic out_free;  // output register can take a result this cycle
  } pom_sts_t;

endpackage

FILE: sv/pom_ram.sv
module pom_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/pom_div.sv
module pom_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic [NUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  quot_r, quot_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DEN_W:0]    rem_sh;
  logic              ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh   = {rem_r, quot_r[NUM_W-1]};
    ge       = (rem_sh >= {1'b0, den_r});
    rem_nxt  = ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
    quot_nxt = {quot_r[NUM_W-2:0], ge};
    step_nxt = step_r - STEP_W'(1);
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (start) begin
      step_r <= STEP_W'(NUM_W);
    end else if (busy) begin
      step_r <= step_nxt;
    end
  end

  // Quotient and remainder shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      den_r  <= divisor;
    end else if (busy) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign busy     = (step_r != '0);
  assign quotient = quot_r;

endmodule

FILE: sv/pom_ctrl.sv
module pom_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  pom_pkg::pom_sts_t sts,
  output pom_pkg::pom_cmd_t cmd
);

  import pom_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        priority if (sts.func) begin
          cmd.clr   = 1'b1;
          state_nxt = ST_FINISH;
        end else if (sts.reject) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold until the previous result has been taken
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/pom_dp.sv
module pom_dp #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pom_pkg::pom_cmd_t                   cmd,
  output pom_pkg::pom_sts_t                   sts,
  input  logic                                in_func,
  input  logic [pom_pkg::RAW_W-1:0]           in_raw,
  input  logic                                cfg_we,
  input  logic [pom_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pom_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pom_pkg::OUT_W-1:0]           out_filtered,
  output logic [pom_pkg::STATUS_W-1:0]        out_status
);

  import pom_pkg::*;

  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int ADDR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_MAX);
  localparam int CMP_W  = (CNT_W > WIN_REG_W) ? CNT_W : WIN_REG_W;
  localparam int SAT_W  = (SAMPLE_BITS > RAW_W) ? SAMPLE_BITS : RAW_W;

  // Configuration registers
  logic [RAW_W-1:0]     zero_offset_r;
  logic [RAW_W-1:0]     neg_tol_r;
  logic [WIN_REG_W-1:0] window_len_r;

  // Captured input
  logic             func_r;
  logic [RAW_W-1:0] raw_r;

  // Filter state
  logic [ADDR_W-1:0] pos_r;
  logic [CNT_W-1:0]  count_r;
  logic [SUM_W-1:0]  sum_r;

  // Result
  logic                ok_r;
  logic [STATUS_W-1:0] res_status_r;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_filtered_r;
  logic [STATUS_W-1:0] out_status_r;

  logic                   win_clr;
  logic [CMP_W-1:0]       win_ext;
  logic [CNT_W-1:0]       win_eff;
  logic                   win_zero;
  logic signed [RAW_W:0]  corr;
  logic signed [RAW_W+1:0] corr_tol;
  logic                   below_tol;
  logic [SAT_W-1:0]       corr_u;
  logic [SAMPLE_BITS-1:0] sample;
  logic [ADDR_W-1:0]      pos_eff;
  logic [ADDR_W-1:0]      pos_inc;
  logic                   full;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [SUM_W-1:0]       sum_nxt;
  logic [CNT_W-1:0]       count_nxt;
  logic [STATUS_W-1:0]    status_code;
  logic                   div_busy;
  logic [SUM_W-1:0]       quotient;

  // Configuration writes; a window write also empties the store
  assign win_clr = cfg_we && (cfg_index == CFG_WINDOW_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_offset_r <= '0;
      neg_tol_r     <= '0;
      window_len_r  <= WINDOW_RESET;
    end else if (cfg_we) begin
      priority case (cfg_index)
        CFG_ZERO_OFFSET: zero_offset_r <= cfg_data[RAW_W-1:0];
        CFG_NEG_TOL:     neg_tol_r     <= cfg_data[RAW_W-1:0];
        CFG_WINDOW_LEN:  window_len_r  <= cfg_data[WIN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r <= in_func;
      raw_r  <= in_raw;
    end
  end

  // Effective window, saturated at the built maximum
  always_comb begin
    win_ext = CMP_W'(window_len_r);
    if (win_ext > CMP_W'(WINDOW_MAX)) begin
      win_eff = CNT_W'(WINDOW_MAX);
    end else begin
      win_eff = CNT_W'(win_ext);
    end
    win_zero = (win_eff == '0);
  end

  // Offset removal, tolerance test, clamp and saturate
  always_comb begin
    corr      = $signed({raw_r[RAW_W-1], raw_r}) -
                $signed({zero_offset_r[RAW_W-1], zero_offset_r});
    corr_tol  = $signed({corr[RAW_W], corr}) + $signed({2'b00, neg_tol_r});
    below_tol = corr_tol[RAW_W+1];
    corr_u    = SAT_W'(corr[RAW_W-1:0]);
    if (corr[RAW_W]) begin
      sample = '0;
    end else if ((corr_u >> SAMPLE_BITS) != '0) begin
      sample = '1;
    end else begin
      sample = SAMPLE_BITS'(corr_u);
    end
  end

  // Ring position and running sum
  always_comb begin
    pos_eff = (CNT_W'(pos_r) >= win_eff) ? '0 : pos_r;
    if (CNT_W'(pos_eff) + CNT_W'(1) == win_eff) begin
      pos_inc = '0;
    end else begin
      pos_inc = pos_eff + ADDR_W'(1);
    end
    full       = (count_r >= win_eff);
    count_nxt  = full ? count_r : count_r + CNT_W'(1);
    sum_nxt    = sum_r - (full ? SUM_W'(old_sample) : '0) + SUM_W'(sample);
  end

  // Status of the captured item
  always_comb begin
    priority if (func_r) begin
      status_code = STATUS_OK;
    end else if (win_zero) begin
      status_code = STATUS_WIN_ZERO;
    end else if (below_tol) begin
      status_code = STATUS_BELOW_TOL;
    end else begin
      status_code = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      res_status_r <= status_code;
      ok_r         <= !func_r && !win_zero && !below_tol;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      count_r <= '0;
      sum_r   <= '0;
    end else if (cmd.clr || win_clr) begin
      pos_r   <= '0;
      count_r <= '0;
      sum_r   <= '0;
    end else if (cmd.update) begin
      pos_r   <= pos_inc;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // Sample ring: read the slot to retire during the check, write it on update
  pom_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (pos_eff),
    .wdata (sample),
    .raddr (pos_eff),
    .rdata (old_sample)
  );

  // Mean of the held samples
  pom_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.update),
    .dividend (sum_nxt),
    .divisor  (count_nxt),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_filtered_r <= ok_r ? OUT_W'(quotient) : '0;
      out_status_r   <= res_status_r;
    end
  end

  assign sts.func     = func_r;
  assign sts.reject   = win_zero || below_tol;
  assign sts.div_busy = div_busy;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;
  assign out_status   = out_status_r;

endmodule

FILE: sv/pressure_offset_moving_average_core.sv
// Channel  Direction  Handshake                 Payload
// in_      slave      in_tvalid / in_tready     tdata: raw_pressure; tuser: func
// out_     master     out_tvalid / out_tready   tdata: filtered_pressure; tuser: status
// cfg_     slave      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A sample's result passes through the states CHECK, UPDATE, DIV and FINISH to the output register;
// its mean comes from the bit-serial divide of the sum by the count held in the window.
// A clear command or a rejected sample goes from CHECK straight to FINISH; no new input is taken before FINISH.
// Synchronous active-low reset; the sample ring needs no clearing pass.
// The next input transfer is taken while a result waits in the output register;
// a stalled output holds the following result until it drains.
module pressure_offset_moving_average_core #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [23:0]                      in_tdata,   // [23:0] raw_pressure
  input  logic [0:0]                       in_tuser,   // [0] func
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [23:0]                      out_tdata,  // [23:0] filtered_pressure
  output logic [1:0]                       out_tuser,  // [1:0] status
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pom_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pom_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import pom_pkg::*;

  pom_cmd_t cmd;
  pom_sts_t sts;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  pom_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pom_dp #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_func      (in_tuser[0]),
    .in_raw       (in_tdata[RAW_W-1:0]),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_filtered (out_tdata[OUT_W-1:0]),
    .out_status   (out_tuser[STATUS_W-1:0])
  );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import pom_pkg::*;

  localparam int  CYCLE_LIMIT  = 1_000_000;
  localparam int  RING_DEPTH   = 64;
  localparam int  PHASES       = 12;
  localparam int  PHASE_ITEMS  = 125;
  localparam int  TAIL_CYCLES  = 40;
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  typedef struct packed {
    logic [OUT_W-1:0]    filtered;
    logic [STATUS_W-1:0] status;
  } avg_result_t;

  typedef enum int {RX_FLOW, RX_CHOPPY, RX_LONG_STALL} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [23:0]           in_tdata;
  logic [0:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [23:0]           out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Filter model: register copy and ring state
  logic signed [23:0]    offset_cfg;
  logic [23:0]           tol_cfg;
  logic [WIN_REG_W-1:0]  window_cfg;
  logic [23:0]           ring_model [RING_DEPTH];
  int                    ring_pos;
  int                    ring_held;
  logic [29:0]           ring_sum;

  avg_result_t           pending_avgs[$];

  int                    errors;
  int                    cycle_count;
  int                    n_accepted, n_clears, n_rejects, n_win_zero, n_cfg_writes;

  // Sender and receiver pacing
  int                    tx_burst_left;
  bit                    tx_steady;
  rx_mode_t              rx_mode;
  int                    rx_mode_left;
  int                    rx_hold;

  pressure_offset_moving_average_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Empty the ring model
  function automatic void empty_ring();
    for (int i = 0; i < RING_DEPTH; i++) ring_model[i] = '0;
    ring_pos  = 0;
    ring_held = 0;
    ring_sum  = '0;
  endfunction

  // Advance the filter model by one transfer and return the expected result
  function automatic avg_result_t predict_average(input logic clr, input logic [23:0] raw);
    avg_result_t res;
    int          win;
    longint      corrected;
    logic [23:0] sample;
    res = '0;
    win = (window_cfg > RING_DEPTH) ? RING_DEPTH : int'(window_cfg);
    if (clr) begin
      empty_ring();
      n_clears++;
      return res;
    end
    if (win == 0) begin
      res.status = STATUS_WIN_ZERO;
      n_win_zero++;
      return res;
    end
    corrected = longint'($signed(raw)) - longint'(offset_cfg);
    if (corrected < -longint'(tol_cfg)) begin
      res.status = STATUS_BELOW_TOL;
      n_rejects++;
      return res;
    end
    // Clamp at zero, saturate at the sample width
    if (corrected < 0)
      sample = '0;
    else if (corrected > longint'(24'hFFFFFF))
      sample = 24'hFFFFFF;
    else
      sample = corrected[23:0];
    if (ring_pos >= win) ring_pos = 0;
    if (ring_held >= win)
      ring_sum = ring_sum - ring_model[ring_pos];
    else
      ring_held++;
    ring_model[ring_pos] = sample;
    ring_sum = ring_sum + sample;
    ring_pos = (ring_pos + 1) % win;
    res.filtered = 24'(longint'(ring_sum) / ring_held);
    res.status   = STATUS_OK;
    n_accepted++;
    return res;
  endfunction

  // Send one item, then idle per the current burst pattern
  task automatic send_item(input logic clr, input logic [23:0] raw);
    in_tuser  = clr;
    in_tdata  = raw;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_avgs.push_back(predict_average(clr, raw));
    @(negedge clk);
    if (tx_burst_left > 0) begin
      tx_burst_left--;
    end else begin
      tx_burst_left = $urandom_range(0, 20);
      if (!tx_steady) begin
        in_tvalid = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  endtask

  // Hold the input idle until every expected result has drained
  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ZERO_OFFSET: offset_cfg = data;
      CFG_NEG_TOL:     tol_cfg = data;
      CFG_WINDOW_LEN: begin
        window_cfg = data[WIN_REG_W-1:0];
        empty_ring();
      end
      default: ;
    endcase
    n_cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [23:0] pick_offset();
    case ($urandom_range(0, 5))
      0:       return 24'h800000;
      1:       return 24'h7FFFFF;
      2:       return 24'h000000;
      3:       return 24'($urandom_range(0, 4000)) - 24'd2000;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_tolerance();
    case ($urandom_range(0, 4))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      2:       return 24'($urandom_range(0, 5000));
      default: return 24'($urandom);
    endcase
  endfunction

  // Random window register value; upper data bits carry noise
  function automatic logic [23:0] pick_window();
    logic [6:0] win;
    case ($urandom_range(0, 9))
      0:       win = 7'($urandom_range(9, 63));
      1:       win = 7'd64;
      2:       win = 7'($urandom_range(65, 127));
      3:       win = 7'd0;
      default: win = 7'($urandom_range(1, 8));
    endcase
    return {17'($urandom), win};
  endfunction

  // Raw sample placed relative to the offset so both outcomes occur often
  function automatic logic [23:0] pick_raw();
    longint delta;
    longint v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: delta = longint'($urandom_range(0, 4000)) - 1000;
      4, 5:       delta = -longint'(tol_cfg) + longint'($urandom_range(0, 6)) - 3;
      6:          return 24'h7FFFFF ^ 24'($urandom_range(0, 1) * 24'hFFFFFF);
      default:    return 24'($urandom);
    endcase
    v = longint'(offset_cfg) + delta;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  // Reset values: offset zero, tolerance zero, window sixteen
  task automatic test_reset_defaults();
    send_item(FUNC_SAMPLE, 24'h000000);
    send_item(FUNC_SAMPLE, 24'h7FFFFF);
    send_item(FUNC_SAMPLE, 24'hFFFFFF);
    send_item(FUNC_SAMPLE, 24'h800000);
    send_item(FUNC_SAMPLE, 24'd100);
    send_item(FUNC_CLEAR, 24'h5A5A5A);
    send_item(FUNC_SAMPLE, 24'd7);
    wait_drained();
  endtask

  // Full-scale corrected values and the tolerance edge
  task automatic test_offset_extremes();
    write_reg(CFG_ZERO_OFFSET, 24'h800000);
    write_reg(CFG_WINDOW_LEN, 24'd2);
    send_item(FUNC_SAMPLE, 24'h7FFFFF);
    send_item(FUNC_SAMPLE, 24'h7FFFFF);
    send_item(FUNC_SAMPLE, 24'h800000);
    wait_drained();
    write_reg(CFG_ZERO_OFFSET, 24'h7FFFFF);
    write_reg(CFG_NEG_TOL, 24'hFFFFFF);
    send_item(FUNC_SAMPLE, 24'h800000);
    wait_drained();
    write_reg(CFG_NEG_TOL, 24'hFFFFFE);
    send_item(FUNC_SAMPLE, 24'h800000);
    wait_drained();
  endtask

  // Window zero, window above the maximum, window one
  task automatic test_window_limits();
    write_reg(CFG_ZERO_OFFSET, 24'h000000);
    write_reg(CFG_NEG_TOL, 24'h000000);
    write_reg(CFG_WINDOW_LEN, 24'd0);
    send_item(FUNC_SAMPLE, 24'd500);
    send_item(FUNC_CLEAR, 24'd0);
    wait_drained();
    write_reg(CFG_WINDOW_LEN, 24'd127);
    send_item(FUNC_SAMPLE, 24'd301);
    send_item(FUNC_SAMPLE, 24'd4);
    wait_drained();
    write_reg(CFG_WINDOW_LEN, 24'd1);
    send_item(FUNC_SAMPLE, 24'd1000);
    send_item(FUNC_SAMPLE, 24'd33);
    wait_drained();
  endtask

  // Random phases, each under its own register setting and pacing
  task automatic test_random_phases();
    int n;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      if (ph == 0 || $urandom_range(0, 1)) write_reg(CFG_ZERO_OFFSET, pick_offset());
      if (ph == 1 || $urandom_range(0, 1)) write_reg(CFG_NEG_TOL, pick_tolerance());
      if (ph == 2)
        write_reg(CFG_WINDOW_LEN, 24'd64);
      else if (ph == 3)
        write_reg(CFG_WINDOW_LEN, 24'd127);
      else if (ph == 4)
        write_reg(CFG_WINDOW_LEN, 24'd0);
      else if ($urandom_range(0, 2) != 0)
        write_reg(CFG_WINDOW_LEN, pick_window());
      tx_steady = ($urandom_range(0, 3) == 0);
      n = (window_cfg == 0) ? 20 : PHASE_ITEMS;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) < 4)
          send_item(FUNC_CLEAR, 24'($urandom));
        else
          send_item(FUNC_SAMPLE, pick_raw());
      end
    end
    wait_drained();
  endtask

  // Receiver stall pattern
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 2));
      rx_mode_left = $urandom_range(50, 400);
    end else begin
      rx_mode_left--;
    end
    if (rx_hold != 0) begin
      rx_hold--;
      out_tready = 1'b0;
    end else begin
      case (rx_mode)
        RX_FLOW:   out_tready = 1'b1;
        RX_CHOPPY: out_tready = ($urandom_range(0, 3) != 0);
        default: begin
          if ($urandom_range(0, 19) == 0) begin
            rx_hold    = $urandom_range(5, 60);
            out_tready = 1'b0;
          end else begin
            out_tready = 1'b1;
          end
        end
      endcase
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    avg_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_avgs.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR %0t: result with none expected: filtered=%0d status=%0d",
                   $realtime, out_tdata, out_tuser);
      end else begin
        exp_res = pending_avgs.pop_front();
        if (out_tdata !== exp_res.filtered || out_tuser !== exp_res.status) begin
          errors++;
          if (errors <= 10)
            $display("ERROR %0t: filtered exp %0d got %0d, status exp %0d got %0d",
                     $realtime, exp_res.filtered, out_tdata, exp_res.status, out_tuser);
        end
      end
    end
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_avgs.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    out_tready    = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_ZERO_OFFSET;
    cfg_data      = '0;
    errors        = 0;
    cycle_count   = 0;
    n_accepted    = 0;
    n_clears      = 0;
    n_rejects     = 0;
    n_win_zero    = 0;
    n_cfg_writes  = 0;
    tx_burst_left = 0;
    tx_steady     = 1'b0;
    rx_mode       = RX_FLOW;
    rx_mode_left  = 0;
    rx_hold       = 0;
    offset_cfg    = '0;
    tol_cfg       = '0;
    window_cfg    = WINDOW_RESET;
    empty_ring();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_offset_extremes();
    test_window_limits();
    test_random_phases();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Averaged %0d samples, %0d clears, %0d below-tolerance rejects",
             n_accepted, n_clears, n_rejects);
    $display("%0d window-zero results, %0d register writes, %0d mismatches",
             n_win_zero, n_cfg_writes, errors);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
sv/pom_pkg.sv
sv/pom_ram.sv
sv/pom_div.sv
sv/pom_ctrl.sv
sv/pom_dp.sv
sv/pressure_offset_moving_average_core.sv
tb/sv/tb.sv
